// ----- sv/bsg_pkg.sv -----
`default_nettype none

package bsg_pkg;

   // opcodes carried in the request tuser field
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_LUT = 2'd0;
   localparam opcode_type OP_PIX = 2'd1;
   localparam opcode_type OP_REQ = 2'd2;

   // configuration register indexes
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type CSR_SRC_WIDTH  = 3'd0;
   localparam csr_addr_type CSR_SRC_HEIGHT = 3'd1;
   localparam csr_addr_type CSR_X_STEP     = 3'd2;
   localparam csr_addr_type CSR_Y_STEP     = 3'd3;
   localparam csr_addr_type CSR_GAMMA_EN   = 3'd4;

   localparam int SIZE_W     = 9;
   localparam int STEP_W     = 25;
   localparam int COORD_W    = 12;
   localparam int FRAC_W     = 16;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 24;
   localparam int CSR_DATA_W = 25;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
   localparam logic [STEP_W-1:0] STEP_RESET = 25'h0010000;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PY   = 7'b0000010,
      ST_AY   = 7'b0000100,
      ST_WT   = 7'b0001000,
      ST_BL   = 7'b0010000,
      ST_GM   = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic en;
      logic accum;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ----- sv/bsg_ram.sv -----
`default_nettype none

module bsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import bsg_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/bsg_mac.sv -----
`default_nettype none

module bsg_mac #(
   parameter int A_W = 25,
   parameter int B_W = 12
) (
   input  logic                   clock,
   input  bsg_pkg::mac_ctrl_type  ctrl,
   input  logic [A_W-1:0]         op_a,
   input  logic [B_W-1:0]         op_b,
   output logic [A_W+B_W-1:0]     result
);
   import bsg_pkg::*;

   localparam int R_W = A_W + B_W;

   logic [R_W-1:0] prod;
   logic [R_W-1:0] acc_ff;
   logic [R_W-1:0] acc_in;

   always_comb begin
      prod   = R_W'(op_a) * R_W'(op_b);
      acc_in = ctrl.accum ? acc_ff + prod : prod;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign result = acc_ff;

endmodule

`default_nettype wire

// ----- sv/bsg_axis.sv -----
`default_nettype none

module bsg_axis #(
   parameter int POS_W = 37,
   parameter int IDX_W = 8,
   parameter int SZ_W  = 9,
   parameter int WB    = 8
) (
   input  logic [POS_W-1:0] pos,
   input  logic [SZ_W-1:0]  size,
   output logic [IDX_W-1:0] idx0,
   output logic [IDX_W-1:0] idx1,
   output logic [WB-1:0]    frac
);
   import bsg_pkg::*;

   localparam int IP_W = POS_W - FRAC_W;

   logic [IP_W-1:0] ip;
   logic [SZ_W-1:0] last;
   logic [SZ_W-1:0] i0;
   logic [SZ_W-1:0] nxt;
   logic [SZ_W-1:0] i1;

   always_comb begin
      ip   = pos[POS_W-1:FRAC_W];
      last = size - SZ_W'(1);
      // integer part past the far edge sticks to the edge
      if (ip >= IP_W'(size)) begin
         i0 = last;
      end else begin
         i0 = SZ_W'(ip);
      end
      nxt  = i0 + SZ_W'(1);
      i1   = (nxt >= size) ? last : nxt;
      idx0 = IDX_W'(i0);
      idx1 = IDX_W'(i1);
      frac = pos[FRAC_W-1 -: WB];
   end

endmodule

`default_nettype wire

// ----- sv/bilinear_scaler_with_gamma.sv -----
`default_nettype none

// channel   direction  transfer when            contents
// req       in         req_tvalid & req_tready  opcode in tuser, item fields in tdata
// rsp       out        rsp_tvalid & rsp_tready  blended pixel, blue/green/red
// csr       in         csr_we                   register index and write data
//
// gamma loads and pixel writes go straight into memory; the block stays idle.
// a pixel request passes the position, weight, blend and optional gamma steps:
// the single multiply-accumulate unit does two position products, four weights
// and twelve channel products, the frame store gives one neighbor per cycle and
// the gamma table one lookup per cycle. req_tready is low while a request is in work.
// a finished pixel waits in the output register while new items are taken.
// reset is synchronous and clears control and configuration, not data or memories.

module bilinear_scaler_with_gamma #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lut_index, lut_value, src_x, src_y, in_blue, in_green, in_red, out_x, out_y
   input  logic [bsg_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_blue, out_green, out_red
   output logic [bsg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_addr,
   input  logic [bsg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bsg_pkg::*;

   localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int IDX_W    = $clog2(MAX_DIM);
   localparam int SZ_W     = $clog2(MAX_DIM + 1);
   localparam int CLAMP_W  = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
   localparam int FS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W   = $clog2(FS_DEPTH);
   localparam int WB       = WEIGHT_BITS;
   localparam int POS_W    = STEP_W + COORD_W;
   localparam int WT_W     = 2 * WB + 1;
   localparam int A_W      = (STEP_W > WT_W) ? STEP_W : WT_W;
   localparam int B_W      = (COORD_W > WB + 1) ? COORD_W : WB + 1;
   localparam int R_W      = A_W + B_W;
   localparam int SHIFT    = 2 * WB;
   localparam int SUM_W    = SHIFT + CHAN_W + 1;
   localparam logic [31:0]      ROW_PITCH = 32'(MAX_WIDTH);
   localparam logic [WB:0]      ONE_W     = (WB + 1)'(1) << WB;
   localparam logic [SUM_W-1:0] HALF      = SUM_W'(1) << (SHIFT - 1);
   localparam logic [3:0]       WT_LAST   = 4'd4;
   localparam logic [3:0]       BL_LAST   = 4'd12;
   localparam logic [3:0]       GM_LAST   = 4'd3;

   // request fields
   opcode_type          req_op;
   logic [7:0]          req_lut_index;
   logic [7:0]          req_lut_value;
   logic [7:0]          req_src_x;
   logic [7:0]          req_src_y;
   logic [PIXEL_W-1:0]  req_pixel;
   logic [COORD_W-1:0]  req_out_x;
   logic [COORD_W-1:0]  req_out_y;
   logic                req_fire;

   // configuration
   logic [SIZE_W-1:0]   src_width_ff, src_width_in;
   logic [SIZE_W-1:0]   src_height_ff, src_height_in;
   logic [STEP_W-1:0]   x_step_ff, x_step_in;
   logic [STEP_W-1:0]   y_step_ff, y_step_in;
   logic                gamma_en_ff, gamma_en_in;
   logic [SZ_W-1:0]     width_sz;
   logic [SZ_W-1:0]     height_sz;

   // sequencer
   state_type           state_ff, state_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [1:0]          cnt_prev;

   // work registers
   logic [COORD_W-1:0]  coord_y_ff;
   logic [IDX_W-1:0]    x0_ff, x1_ff, y0_ff, y1_ff;
   logic [WB-1:0]       fx_ff, fy_ff;
   logic [WB:0]         fxi, fyi;
   logic [WT_W-1:0]     w_ff [4];
   logic [PIXEL_W-1:0]  pix_ff [4];
   logic [CHAN_W-1:0]   chan_ff [3];

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // shared unit
   mac_ctrl_type        mac_ctrl;
   logic [A_W-1:0]      mac_a;
   logic [B_W-1:0]      mac_b;
   logic [R_W-1:0]      mac_res;
   logic [CHAN_W-1:0]   blend_byte;

   // axis split
   logic [SZ_W-1:0]     ax_size;
   logic [IDX_W-1:0]    ax_i0, ax_i1;
   logic [WB-1:0]       ax_frac;

   // rounding
   logic [SUM_W-1:0]    rnd;
   logic [CHAN_W:0]     rnd_top;
   logic [CHAN_W-1:0]   blend_val;

   // memories
   logic                fs_we;
   logic [ADDR_W-1:0]   fs_waddr;
   logic                fs_re;
   logic [ADDR_W-1:0]   fs_raddr;
   logic [PIXEL_W-1:0]  fs_rdata;
   logic [IDX_W-1:0]    rd_x, rd_y;
   logic                lut_we;
   logic                lut_re;
   logic [7:0]          lut_raddr;
   logic [CHAN_W-1:0]   lut_rdata;

   always_comb begin
      req_op        = opcode_type'(req_tuser);
      req_lut_index = req_tdata[7:0];
      req_lut_value = req_tdata[15:8];
      req_src_x     = req_tdata[23:16];
      req_src_y     = req_tdata[31:24];
      req_pixel     = req_tdata[55:32];
      req_out_x     = req_tdata[67:56];
      req_out_y     = req_tdata[79:68];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // configuration writes
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      x_step_in     = x_step_ff;
      y_step_in     = y_step_ff;
      gamma_en_in   = gamma_en_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_WIDTH:  src_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_SRC_HEIGHT: src_height_in = csr_wdata[SIZE_W-1:0];
            CSR_X_STEP:     x_step_in     = csr_wdata[STEP_W-1:0];
            CSR_Y_STEP:     y_step_in     = csr_wdata[STEP_W-1:0];
            CSR_GAMMA_EN:   gamma_en_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // size registers limited to 1 .. max
   always_comb begin
      if (src_width_ff == '0) begin
         width_sz = SZ_W'(1);
      end else if (CLAMP_W'(src_width_ff) > CLAMP_W'(MAX_WIDTH)) begin
         width_sz = SZ_W'(MAX_WIDTH);
      end else begin
         width_sz = SZ_W'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         height_sz = SZ_W'(1);
      end else if (CLAMP_W'(src_height_ff) > CLAMP_W'(MAX_HEIGHT)) begin
         height_sz = SZ_W'(MAX_HEIGHT);
      end else begin
         height_sz = SZ_W'(src_height_ff);
      end
   end

   assign fxi      = ONE_W - (WB + 1)'(fx_ff);
   assign fyi      = ONE_W - (WB + 1)'(fy_ff);
   assign cnt_prev = 2'(cnt_ff - 4'd1);

   // operand selection for the shared multiply-accumulate
   always_comb begin
      mac_ctrl   = '0;
      mac_a      = '0;
      mac_b      = '0;
      blend_byte = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_REQ) begin
               mac_ctrl.en = 1'b1;
               mac_a       = A_W'(x_step_ff);
               mac_b       = B_W'(req_out_x);
            end
         end
         ST_PY: begin
            mac_ctrl.en = 1'b1;
            mac_a       = A_W'(y_step_ff);
            mac_b       = B_W'(coord_y_ff);
         end
         ST_WT: begin
            // weight k: bit 0 picks fx over 1-fx, bit 1 picks fy over 1-fy
            if (cnt_ff < WT_LAST) begin
               mac_ctrl.en = 1'b1;
               mac_a       = cnt_ff[0] ? A_W'(fx_ff) : A_W'(fxi);
               mac_b       = cnt_ff[1] ? B_W'(fy_ff) : B_W'(fyi);
            end
         end
         ST_BL: begin
            if (cnt_ff < BL_LAST) begin
               blend_byte     = pix_ff[cnt_ff[1:0]][{cnt_ff[3:2], 3'b000} +: CHAN_W];
               mac_ctrl.en    = 1'b1;
               mac_ctrl.accum = (cnt_ff[1:0] != 2'd0);
               mac_a          = A_W'(w_ff[cnt_ff[1:0]]);
               mac_b          = B_W'(blend_byte);
            end
         end
         ST_AY, ST_GM, ST_DONE: ;
         default: ;
      endcase
   end

   bsg_mac #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .result (mac_res)
   );

   assign ax_size = (state_ff == ST_PY) ? width_sz : height_sz;

   bsg_axis #(
      .POS_W (POS_W),
      .IDX_W (IDX_W),
      .SZ_W  (SZ_W),
      .WB    (WB)
   ) u_axis (
      .pos  (mac_res[POS_W-1:0]),
      .size (ax_size),
      .idx0 (ax_i0),
      .idx1 (ax_i1),
      .frac (ax_frac)
   );

   // round at half, drop the weight bits, saturate
   always_comb begin
      rnd       = mac_res[SUM_W-1:0] + HALF;
      rnd_top   = rnd[SUM_W-1:SHIFT];
      blend_val = rnd_top[CHAN_W] ? {CHAN_W{1'b1}} : rnd_top[CHAN_W-1:0];
   end

   // frame store ports
   always_comb begin
      fs_we    = req_fire && req_op == OP_PIX &&
                 32'(req_src_x) < ROW_PITCH && 32'(req_src_y) < 32'(MAX_HEIGHT);
      fs_waddr = ADDR_W'(32'(req_src_y) * ROW_PITCH + 32'(req_src_x));
      fs_re    = (state_ff == ST_WT) && (cnt_ff < WT_LAST);
      rd_x     = cnt_ff[0] ? x1_ff : x0_ff;
      rd_y     = cnt_ff[1] ? y1_ff : y0_ff;
      fs_raddr = ADDR_W'(32'(rd_y) * ROW_PITCH + 32'(rd_x));
   end

   bsg_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (FS_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (req_pixel),
      .rd_en   (fs_re),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

   assign lut_we    = req_fire && req_op == OP_LUT;
   assign lut_re    = (state_ff == ST_GM) && (cnt_ff < GM_LAST);
   assign lut_raddr = chan_ff[cnt_ff[1:0]];

   bsg_ram #(
      .WIDTH (CHAN_W),
      .DEPTH (256)
   ) u_gamma_table (
      .clock   (clock),
      .wr_en   (lut_we),
      .wr_addr (req_lut_index),
      .wr_data (req_lut_value),
      .rd_en   (lut_re),
      .rd_addr (lut_raddr),
      .rd_data (lut_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_REQ) begin
               state_in = ST_PY;
            end
         end
         ST_PY: begin
            state_in = ST_AY;
         end
         ST_AY: begin
            state_in = ST_WT;
            cnt_in   = '0;
         end
         ST_WT: begin
            if (cnt_ff == WT_LAST) begin
               state_in = ST_BL;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_BL: begin
            if (cnt_ff == BL_LAST) begin
               state_in = gamma_en_ff ? ST_GM : ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_GM: begin
            if (cnt_ff == GM_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= SIZE_RESET;
         src_height_ff <= SIZE_RESET;
         x_step_ff     <= STEP_RESET;
         y_step_ff     <= STEP_RESET;
         gamma_en_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         x_step_ff     <= x_step_in;
         y_step_ff     <= y_step_in;
         gamma_en_ff   <= gamma_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         coord_y_ff <= req_out_y;
      end
      if (state_ff == ST_PY) begin
         x0_ff <= ax_i0;
         x1_ff <= ax_i1;
         fx_ff <= ax_frac;
      end
      if (state_ff == ST_AY) begin
         y0_ff <= ax_i0;
         y1_ff <= ax_i1;
         fy_ff <= ax_frac;
      end
      // weight and neighbor of the previous step arrive together
      if (state_ff == ST_WT && cnt_ff != 4'd0) begin
         w_ff[cnt_prev]   <= mac_res[WT_W-1:0];
         pix_ff[cnt_prev] <= fs_rdata;
      end
      // a channel sum is complete when the next channel starts
      if (state_ff == ST_BL && cnt_ff != 4'd0 && cnt_ff[1:0] == 2'd0) begin
         chan_ff[2'(cnt_ff[3:2] - 2'd1)] <= blend_val;
      end
      if (state_ff == ST_GM && cnt_ff != 4'd0) begin
         chan_ff[cnt_prev] <= lut_rdata;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {chan_ff[2], chan_ff[1], chan_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_req_starts_sequence: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == OP_REQ |=> state_ff == ST_PY)
      else $error("pixel request did not start the position step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done step");

   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      fs_we || lut_we |-> state_ff == ST_IDLE)
      else $error("memory written while a request is in work");

   a_blend_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BL |-> cnt_ff <= BL_LAST)
      else $error("blend step count out of range");

endmodule

`default_nettype wire

// ----- tb/bilinear_scaler_with_gamma_tb.sv -----
`timescale 1ns / 100ps

module bilinear_scaler_with_gamma_tb;
   import bsg_pkg::*;

   localparam int MAX_W       = 256;
   localparam int MAX_H       = 256;
   localparam int WT_BITS     = 8;
   localparam int ONE         = 1 << WT_BITS;
   localparam int ROUND       = 1 << (2 * WT_BITS - 1);
   localparam int CHAN_MAX    = 255;
   localparam int MAX_GAP     = 17;
   localparam int HOLD_OFF    = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int FILL_MAX    = 64;

   // opcode the block ignores, and the highest register index past the list
   localparam opcode_type   OP_NONE    = 2'd3;
   localparam csr_addr_type CSR_BEYOND = 3'd7;

   typedef struct packed {
      logic [11:0] out_y;
      logic [11:0] out_x;
      logic [7:0]  in_red;
      logic [7:0]  in_green;
      logic [7:0]  in_blue;
      logic [7:0]  src_y;
      logic [7:0]  src_x;
      logic [7:0]  lut_value;
      logic [7:0]  lut_index;
   } req_fields_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // lut_index, lut_value, src_x, src_y, in_blue, in_green, in_red, out_x, out_y
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // opcode
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // out_blue, out_green, out_red
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block state
   bit [23:0]   src_pixels[MAX_W * MAX_H];
   bit          pixel_written[MAX_W * MAX_H];
   bit [7:0]    curve_shadow[256];
   bit          lut_written[256];
   logic [8:0]  cfg_width = 9'd256;
   logic [8:0]  cfg_height = 9'd256;
   logic [24:0] cfg_x_step = 25'h0010000;
   logic [24:0] cfg_y_step = 25'h0010000;
   logic        cfg_gamma_en = 1'b0;

   pixel_type expected_pixels[$];
   pixel_type got, want;
   int     mismatch_count = 0;
   int     stalled_cycles = 0;
   int     rsp_hold = 0;
   bit     rsp_fired = 1'b0;
   bit     req_burst = 1'b0;
   bit     rsp_burst = 1'b0;

   bilinear_scaler_with_gamma u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int clamp_size(input logic [8:0] size_reg, input int limit);
      if (size_reg == 0) return 1;
      if (size_reg > limit) return limit;
      return int'(size_reg);
   endfunction

   // neighbor indexes and weight along one axis
   function automatic void axis_split(input logic [11:0] coord, input logic [24:0] step,
         input logic [8:0] size_reg, output int i0, output int i1, output int frac);
      logic [36:0] pos;
      int          n;
      pos  = 37'(coord) * 37'(step);
      n    = clamp_size(size_reg, MAX_W);
      frac = int'(pos[FRAC_W-1:FRAC_W-WT_BITS]);
      if (pos[36:FRAC_W] >= 21'(n)) i0 = n - 1;
      else i0 = int'(pos[36:FRAC_W]);
      i1 = (i0 + 1 >= n) ? n - 1 : i0 + 1;
   endfunction

   // blended and mapped pixel; known drops if any entry read was never written
   function automatic logic [23:0] scaled_pixel(input logic [11:0] ox, input logic [11:0] oy,
         output bit known);
      int          x0, x1, y0, y1, fx, fy;
      int unsigned w00, w01, w10, w11, acc, v;
      bit [23:0]   p00, p01, p10, p11;
      logic [23:0] result;
      axis_split(ox, cfg_x_step, cfg_width, x0, x1, fx);
      axis_split(oy, cfg_y_step, cfg_height, y0, y1, fy);
      w00 = (ONE - fx) * (ONE - fy);
      w01 = fx * (ONE - fy);
      w10 = (ONE - fx) * fy;
      w11 = fx * fy;
      known = pixel_written[y0 * MAX_W + x0] && pixel_written[y0 * MAX_W + x1] &&
              pixel_written[y1 * MAX_W + x0] && pixel_written[y1 * MAX_W + x1];
      p00 = src_pixels[y0 * MAX_W + x0];
      p01 = src_pixels[y0 * MAX_W + x1];
      p10 = src_pixels[y1 * MAX_W + x0];
      p11 = src_pixels[y1 * MAX_W + x1];
      for (int c = 0; c < 3; c++) begin
         acc = p00[8*c +: 8] * w00 + p01[8*c +: 8] * w01 +
               p10[8*c +: 8] * w10 + p11[8*c +: 8] * w11;
         v = (acc + ROUND) >> (2 * WT_BITS);
         if (v > CHAN_MAX) v = CHAN_MAX;
         if (cfg_gamma_en) begin
            known = known && lut_written[v];
            v = curve_shadow[v];
         end
         result[8*c +: 8] = 8'(v);
      end
      return result;
   endfunction

   function automatic req_fields_type random_fields();
      logic [95:0] raw_bits;
      raw_bits = {$urandom, $urandom, $urandom};
      return req_fields_type'(raw_bits[REQ_DATA_W-1:0]);
   endfunction

   function automatic logic [24:0] pick_step();
      case ($urandom_range(0, 9))
         0: return 25'h0000000;
         1: return 25'h1FFFFFF;
         2: return 25'h1000000;
         3: return 25'h0010000;
         default: return 25'($urandom_range(0, 25'h3FFFF));
      endcase
   endfunction

   function automatic logic [8:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(1, 8));
      endcase
   endfunction

   // size registers keep nine bits, the rest of the word is junk at times
   function automatic logic [24:0] size_word(input logic [8:0] s);
      logic [15:0] junk;
      junk = 16'($urandom);
      return ($urandom_range(0, 3) == 0) ? {junk, s} : {16'b0, s};
   endfunction

   task automatic report_mismatch(input string what, input int got_val, input int want_val);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got_val, want_val);
      mismatch_count++;
   endtask

   task automatic send_item(input opcode_type op, input req_fields_type f);
      int          gap;
      bit          known;
      logic [23:0] px;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_LUT: begin
            curve_shadow[f.lut_index] = f.lut_value;
            lut_written[f.lut_index]  = 1'b1;
         end
         OP_PIX: begin
            src_pixels[{f.src_y, f.src_x}]    = {f.in_red, f.in_green, f.in_blue};
            pixel_written[{f.src_y, f.src_x}] = 1'b1;
         end
         OP_REQ: begin
            px = scaled_pixel(f.out_x, f.out_y, known);
            expected_pixels.push_back(px);
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_gamma(input logic [7:0] idx, input logic [7:0] val);
      req_fields_type f;
      f = random_fields();
      f.lut_index = idx;
      f.lut_value = val;
      send_item(OP_LUT, f);
   endtask

   task automatic write_source(input logic [7:0] x, input logic [7:0] y, input logic [23:0] bgr);
      req_fields_type f;
      f = random_fields();
      f.src_x = x;
      f.src_y = y;
      {f.in_red, f.in_green, f.in_blue} = bgr;
      send_item(OP_PIX, f);
   endtask

   task automatic request_pixel(input logic [11:0] ox, input logic [11:0] oy);
      req_fields_type f;
      f = random_fields();
      f.out_x = ox;
      f.out_y = oy;
      send_item(OP_REQ, f);
   endtask

   task automatic send_noise();
      send_item(OP_NONE, random_fields());
   endtask

   // only positions whose neighbors and table entries are all written
   task automatic request_random();
      logic [11:0] ox, oy;
      bit          known;
      for (int k = 0; k < 40; k++) begin
         case ($urandom_range(0, 2))
            0: begin
               ox = 12'($urandom);
               oy = 12'($urandom);
            end
            1: begin
               ox = 12'($urandom_range(0, 15));
               oy = 12'($urandom_range(0, 15));
            end
            default: begin
               ox = 12'($urandom_range(0, 63));
               oy = 12'($urandom_range(0, 63));
            end
         endcase
         void'(scaled_pixel(ox, oy, known));
         if (known) begin
            request_pixel(ox, oy);
            return;
         end
      end
      void'(scaled_pixel(12'd0, 12'd0, known));
      if (known) request_pixel(12'd0, 12'd0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   // only called while the block is idle
   task automatic write_reg(input csr_addr_type addr, input logic [24:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (addr)
         CSR_SRC_WIDTH:  cfg_width    = value[8:0];
         CSR_SRC_HEIGHT: cfg_height   = value[8:0];
         CSR_X_STEP:     cfg_x_step   = value;
         CSR_Y_STEP:     cfg_y_step   = value;
         CSR_GAMMA_EN:   cfg_gamma_en = value[0];
         default: ;
      endcase
   endtask

   task automatic test_reset_defaults();
      write_source(8'd0, 8'd0, 24'hFFFFFF);
      write_source(8'd1, 8'd0, 24'h000000);
      write_source(8'd0, 8'd1, 24'($urandom));
      write_source(8'd1, 8'd1, 24'($urandom));
      write_source(8'd254, 8'd254, 24'($urandom));
      write_source(8'd255, 8'd254, 24'($urandom));
      write_source(8'd254, 8'd255, 24'($urandom));
      write_source(8'd255, 8'd255, 24'($urandom));
      request_pixel(12'd0, 12'd0);
      request_pixel(12'd254, 12'd254);
      request_pixel(12'd255, 12'd255);
      // far past the source, clamps to the corner
      request_pixel(12'hFFF, 12'hFFF);
      send_noise();
   endtask

   task automatic test_config_extremes();
      wait_drained();
      write_reg(CSR_X_STEP, 25'h0008000);
      write_reg(CSR_Y_STEP, 25'h0004000);
      request_pixel(12'd1, 12'd1);
      request_pixel(12'd1, 12'd0);
      request_pixel(12'd0, 12'd1);
      // zero sizes count as one pixel
      wait_drained();
      write_reg(CSR_SRC_WIDTH, 25'd0);
      write_reg(CSR_SRC_HEIGHT, 25'd0);
      request_pixel(12'hFFF, 12'hFFF);
      request_pixel(12'd3, 12'd0);
      // oversize source and huge steps
      wait_drained();
      write_reg(CSR_SRC_WIDTH, 25'h00001FF);
      write_reg(CSR_SRC_HEIGHT, 25'd300);
      write_reg(CSR_X_STEP, 25'h1FFFFFF);
      write_reg(CSR_Y_STEP, 25'h1000000);
      request_pixel(12'd1, 12'd1);
      request_pixel(12'hFFF, 12'hFFF);
      request_pixel(12'd0, 12'd0);
      // zero step, and a write past the register list that must change nothing
      wait_drained();
      write_reg(CSR_X_STEP, 25'd0);
      write_reg(CSR_Y_STEP, 25'd0);
      write_reg(CSR_BEYOND, 25'h1FFFFFF);
      request_pixel(12'($urandom), 12'($urandom));
      request_pixel(12'hFFF, 12'd0);
   endtask

   task automatic test_gamma_table();
      wait_drained();
      for (int i = 0; i < 256; i++) begin
         req_burst = (i < 128);
         if (i == 0) load_gamma(8'(i), 8'hFF);
         else if (i == 1) load_gamma(8'(i), 8'h00);
         else load_gamma(8'(i), 8'($urandom));
      end
      req_burst = 1'b0;
      wait_drained();
      write_reg(CSR_GAMMA_EN, 25'd1);
      write_reg(CSR_SRC_WIDTH, 25'd2);
      write_reg(CSR_SRC_HEIGHT, 25'd2);
      write_reg(CSR_X_STEP, 25'h0004000);
      write_reg(CSR_Y_STEP, 25'h000C000);
      repeat (12) request_random();
      send_noise();
   endtask

   task automatic test_random_phases();
      logic [8:0]   w_reg, h_reg;
      int           w, h, r;
      csr_addr_type spare;
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         w_reg = pick_size();
         h_reg = pick_size();
         write_reg(CSR_SRC_WIDTH, size_word(w_reg));
         write_reg(CSR_SRC_HEIGHT, size_word(h_reg));
         write_reg(CSR_X_STEP, pick_step());
         write_reg(CSR_Y_STEP, pick_step());
         write_reg(CSR_GAMMA_EN, 25'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) == 0) begin
            spare = csr_addr_type'($urandom_range(CSR_GAMMA_EN + 1, CSR_BEYOND));
            write_reg(spare, 25'($urandom));
         end
         w = clamp_size(w_reg, MAX_W);
         h = clamp_size(h_reg, MAX_H);
         if (w * h <= FILL_MAX) begin
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++)
                  write_source(8'(x), 8'(y), 24'($urandom));
         end else begin
            // origin block and far corner, the rest stays sparse
            for (int y = 0; y < 4 && y < h; y++)
               for (int x = 0; x < 4 && x < w; x++)
                  write_source(8'(x), 8'(y), 24'($urandom));
            for (int y = (h > 2 ? h - 2 : 0); y < h; y++)
               for (int x = (w > 2 ? w - 2 : 0); x < w; x++)
                  write_source(8'(x), 8'(y), 24'($urandom));
         end
         for (int n = 0; n < 20; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) request_random();
            else if (r < 68)
               write_source(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                            24'($urandom));
            else if (r < 75) write_source(8'($urandom), 8'($urandom), 24'($urandom));
            else if (r < 85) load_gamma(8'($urandom), 8'($urandom));
            else if (r < 92) send_noise();
            else if (r < 95) wait_drained();
            else request_random();
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_fired = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_fired = 1'b1;
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), -1);
         end else begin
            want = expected_pixels.pop_front();
            if (got.blue !== want.blue) report_mismatch("out_blue", got.blue, want.blue);
            if (got.green !== want.green) report_mismatch("out_green", got.green, want.green);
            if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
         end
      end
   end

   // result side back-pressure, a fresh random stall, possibly none, after every transfer outside bursts
   always @(negedge clock) begin
      if (rsp_fired) rsp_hold = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("bilinear_scaler_with_gamma_tb failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_config_extremes();
      test_gamma_table();
      test_random_phases();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("bilinear_scaler_with_gamma_tb passed");
      end else begin
         $display("bilinear_scaler_with_gamma_tb failed");
      end
      $finish;
   end

endmodule
